/* sv/avm_pkg.sv */
// Package for the acceleration vector magnitude block: widths, pipeline sizes and root steps.
package avm_pkg;

    localparam int unsigned RAW_W     = 16;
    localparam int unsigned SQ_W      = 31;  // (2^15)^2 = 2^30 needs 31 bits
    localparam int unsigned SUM_W     = 32;  // 3 * 2^30 < 2^32
    localparam int unsigned ROOT_W    = 24;
    localparam int unsigned REM_W     = 26;
    localparam int unsigned RANGE_W   = 2;
    localparam int unsigned SCALE_W   = 6;
    localparam int unsigned PROD_W    = ROOT_W + SCALE_W;
    localparam int unsigned SHIFT_W   = PROD_W + 3;
    localparam int unsigned MICRO_W   = 25;
    localparam int unsigned FRAC_SH   = 8;
    localparam int unsigned PRE_SH    = 16;
    localparam int unsigned BITS_STG  = 2;   // root bits resolved per stage
    localparam int unsigned RT_STG    = ROOT_W / BITS_STG;
    localparam int unsigned NUM_STG   = RT_STG + 3;

    localparam logic [SCALE_W-1:0] SCALE_NUM = 6'd61;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_rt_state;

    // Magnitude of a two's complement sample; the most negative value maps to 2^15.
    function automatic logic [RAW_W-1:0] abs16(input logic [RAW_W-1:0] u);
        abs16 = u[RAW_W-1] ? RAW_W'(~u + 1'b1) : u;
    endfunction

    // Radicand bit pair for step i of the root, radicand = sum << PRE_SH.
    function automatic logic [1:0] rad_pair(input logic [SUM_W-1:0] sum, input int unsigned i);
        logic [1:0] pair;
        pair = 2'b00;
        if (2 * i >= PRE_SH) begin
            pair = sum[2 * i - PRE_SH +: 2];
        end
        rad_pair = pair;
    endfunction

    // One restoring digit step: bring in two radicand bits, try root bit one.
    function automatic t_rt_state rt_step(input t_rt_state cur, input logic [1:0] pair);
        logic [REM_W+1:0] part;
        logic [REM_W+1:0] trial;
        t_rt_state        nxt;
        part  = {cur.rem, pair};
        trial = {2'b00, cur.root, 2'b01};
        if (part >= trial) begin
            nxt.rem  = REM_W'(part - trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = REM_W'(part);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        rt_step = nxt;
    endfunction

endpackage

/* sv/accel_vector_magnitude.sv */
// Three-axis acceleration vector magnitude: sum of squares, pipelined square root, scaling.
//
// Each input word carries one signed 16-bit sample per axis. The block returns
// floor(sqrt((x^2 + y^2 + z^2) << 16)), the raw magnitude with 8 fraction
// bits, and that value times 61 times the range multiplier (1 << range code)
// shifted right 8, the magnitude in micro-g. The datapath is a 15-stage
// pipeline: one stage squares the three axes, one adds them, twelve stages
// each resolve two bits of the 24-bit root, and one stage scales and holds
// the output word. A word is accepted every cycle when the output side keeps
// up. Each stage advances as soon as the stage after it is free, so a stalled
// output fills empty stages first and input ready only drops once every stage
// holds a word. Both ready outputs stay low while reset is held. The range
// code comes from a one-register write port that is ready whenever reset is
// released; write it only while no word is in flight. It resets to 0 (+-2 g).
module accel_vector_magnitude (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [avm_pkg::RANGE_W-1:0]   i_cfg_range_code,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [avm_pkg::RAW_W-1:0] i_raw_x,
    input  logic signed [avm_pkg::RAW_W-1:0] i_raw_y,
    input  logic signed [avm_pkg::RAW_W-1:0] i_raw_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [avm_pkg::ROOT_W-1:0]    o_magnitude_raw_q8,
    output logic [avm_pkg::MICRO_W-1:0]   o_magnitude_micro_g
);

    localparam int unsigned NS      = avm_pkg::NUM_STG;
    localparam int unsigned RT      = avm_pkg::RT_STG;
    localparam int unsigned S_SQ    = 0;
    localparam int unsigned S_SUM   = 1;
    localparam int unsigned S_RT0   = 2;
    localparam int unsigned S_OUT   = NS - 1;

    // Range register
    logic [avm_pkg::RANGE_W-1:0] r_range_code;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_code <= '0;
        end else if (i_cfg_valid) begin
            r_range_code <= i_cfg_range_code;
        end
    end

    // Stage valid bits and advance chain
    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[S_OUT] = !r_vld[S_OUT] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_ready  = adv[S_SQ] && i_rst_n;
    assign o_out_valid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[S_SQ]) begin
                r_vld[S_SQ] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Square stage
    logic [avm_pkg::SQ_W-1:0] r_sq_x, r_sq_y, r_sq_z;
    logic [avm_pkg::RAW_W-1:0] mag_x, mag_y, mag_z;

    assign mag_x = avm_pkg::abs16(i_raw_x);
    assign mag_y = avm_pkg::abs16(i_raw_y);
    assign mag_z = avm_pkg::abs16(i_raw_z);

    always_ff @(posedge i_clk) begin
        if (adv[S_SQ]) begin
            r_sq_x <= avm_pkg::SQ_W'(mag_x * mag_x);
            r_sq_y <= avm_pkg::SQ_W'(mag_y * mag_y);
            r_sq_z <= avm_pkg::SQ_W'(mag_z * mag_z);
        end
    end

    // Sum stage
    logic [avm_pkg::SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (adv[S_SUM]) begin
            r_sum <= avm_pkg::SUM_W'(r_sq_x) + avm_pkg::SUM_W'(r_sq_y)
                   + avm_pkg::SUM_W'(r_sq_z);
        end
    end

    // Root stages: two digit steps each, most significant first
    avm_pkg::t_rt_state        r_rt    [RT];
    logic [avm_pkg::SUM_W-1:0] r_rt_sum[RT];

    for (genvar j = 0; j < RT; j++) begin : g_rt
        avm_pkg::t_rt_state        src;
        avm_pkg::t_rt_state        mid;
        avm_pkg::t_rt_state        n_rt;
        logic [avm_pkg::SUM_W-1:0] src_sum;

        if (j == 0) begin : g_first
            assign src     = '0;
            assign src_sum = r_sum;
        end else begin : g_next
            assign src     = r_rt[j-1];
            assign src_sum = r_rt_sum[j-1];
        end

        assign mid  = avm_pkg::rt_step(src,
                          avm_pkg::rad_pair(src_sum, avm_pkg::ROOT_W - 1 - 2 * j));
        assign n_rt = avm_pkg::rt_step(mid,
                          avm_pkg::rad_pair(src_sum, avm_pkg::ROOT_W - 2 - 2 * j));

        always_ff @(posedge i_clk) begin
            if (adv[S_RT0 + j]) begin
                r_rt[j]     <= n_rt;
                r_rt_sum[j] <= src_sum;
            end
        end
    end

    // Scale stage: q8 * 61, shift by range, drop 8 fraction bits
    logic [avm_pkg::ROOT_W-1:0]  root_fin;
    logic [avm_pkg::PROD_W-1:0]  prod;
    logic [avm_pkg::SHIFT_W-1:0] scaled;
    logic [avm_pkg::ROOT_W-1:0]  r_q8;
    logic [avm_pkg::MICRO_W-1:0] r_micro;

    assign root_fin = r_rt[RT-1].root;
    assign prod     = avm_pkg::PROD_W'(root_fin) * avm_pkg::PROD_W'(avm_pkg::SCALE_NUM);
    assign scaled   = avm_pkg::SHIFT_W'(prod) << r_range_code;

    always_ff @(posedge i_clk) begin
        if (adv[S_OUT]) begin
            r_q8    <= root_fin;
            r_micro <= scaled[avm_pkg::FRAC_SH +: avm_pkg::MICRO_W];
        end
    end

    assign o_magnitude_raw_q8  = r_q8;
    assign o_magnitude_micro_g = r_micro;

    // Checks
    localparam int unsigned RAD_W = avm_pkg::SUM_W + avm_pkg::PRE_SH;

    // A full pipeline with a stalled output must refuse input.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while every stage is full and output stalled");

    // Last root stage: radicand equals root squared plus remainder.
    a_root_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_RT0 + RT - 1] |->
            ({r_rt_sum[RT-1], {avm_pkg::PRE_SH{1'b0}}} ==
             RAD_W'(root_fin) * RAD_W'(root_fin) + RAD_W'(r_rt[RT-1].rem)))
        else $error("root and remainder do not rebuild the radicand");

    // Floor property: remainder never exceeds twice the root.
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_RT0 + RT - 1] |->
            ({1'b0, r_rt[RT-1].rem} <= {root_fin, 1'b0} + 1'b0))
        else $error("root is not the floor square root");

    // A held output word keeps its value while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            ($stable(o_magnitude_raw_q8) && $stable(o_magnitude_micro_g)))
        else $error("stalled output word changed");

endmodule
